### design/cmdl_pkg.sv
// Shared constants, widths and control types for the modulated delay line.
package cmdl_pkg;

   // Store geometry (buffer depth is a power of two, channel index is one bit)
   localparam int BUFFER_DEPTH = 8192;
   localparam int CHANNELS     = 2;
   localparam int FRAC_BITS    = 8;
   localparam int CH_W         = 1;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int MEM_AW       = CH_W + PTR_W;
   localparam int MEM_DEPTH    = CHANNELS * BUFFER_DEPTH;
   localparam int TAPS         = 4;
   localparam int STEP_W       = $clog2(TAPS);

   // Sample and register widths
   localparam int SMP_W     = 16;
   localparam int LFO_FRAC  = 15;
   localparam int REG_W     = 21;
   localparam int CSR_IDX_W = 2;

   // Delay arithmetic widths
   localparam int POS_W  = PTR_W + FRAC_BITS;
   localparam int PROD_W = REG_W + 1 + SMP_W;
   localparam int MOD_W  = PROD_W - LFO_FRAC;
   localparam int DSUM_W = MOD_W + 1;

   // Interpolation widths: weights are exact at scale 2^WSCALE
   localparam int WSCALE = 3 * FRAC_BITS + 1;
   localparam int W_W    = 3 * FRAC_BITS + 3;
   localparam int IW     = W_W + 1;
   localparam int P_W    = W_W + SMP_W;
   localparam int ACC_W  = P_W + 2;
   localparam int Y_W    = ACC_W - WSCALE;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX    = 2'd3;

   // Register reset values
   localparam logic [REG_W-1:0] CENTRE_RST = 21'd245760;
   localparam logic [REG_W-1:0] DEPTH_RST  = 21'd245760;
   localparam logic [REG_W-1:0] GUARD_RST  = 21'd512;
   localparam logic [REG_W-1:0] MAX_RST    = 21'd1352704;

   // Sequencer strobes shared by the datapath units
   typedef struct packed {
      logic              load_mod;
      logic              load_dly;
      logic              load_pos;
      logic              rd_en;
      logic [STEP_W-1:0] step;
      logic              load_prod;
   } cmdl_ctl_type;

endpackage

### design/cmdl_req_if.sv
// Input channel: one beat carries channel, sample and LFO value.
interface cmdl_req_if;
   import cmdl_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CH_W-1:0]         channel;
   logic signed [SMP_W-1:0] sample_in;
   logic signed [SMP_W-1:0] lfo_value;

   modport source (output valid, channel, sample_in, lfo_value, input ready);
   modport sink   (input valid, channel, sample_in, lfo_value, output ready);

endinterface

### design/cmdl_rsp_if.sv
// Result channel: one beat carries the interpolated output sample.
interface cmdl_rsp_if;
   import cmdl_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [SMP_W-1:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);

endinterface

### design/cubic_modulated_delay_line.sv
// Top level: per-channel modulated delay line with 4-point cubic interpolation.
// The result beat is offered after the delay, position, tap read, product and sum steps.
// One item is in work at a time: the four tap reads go through the single memory read port,
// and a new item is taken only when idle or in the sum step of the previous one.
// Reset: pointers, fill marks, registers and handshakes take their reset values; no clearing pass.
module cubic_modulated_delay_line (
   input  logic                              clock,
   input  logic                              reset,
   cmdl_req_if.sink                          req_bus,
   cmdl_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [cmdl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cmdl_pkg::REG_W-1:0]        csr_wr_data
);
   import cmdl_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DLY  = 3'd1;
   localparam logic [2:0] ST_POS  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_SUM  = 3'd5;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TAPS - 1);

   logic [2:0]              state_ff;
   logic [2:0]              state_in;
   logic [STEP_W-1:0]       step_ff;
   logic [STEP_W-1:0]       step_in;
   logic [CH_W-1:0]         ch_ff;
   logic [REG_W-1:0]        centre_ff;
   logic [REG_W-1:0]        depth_ff;
   logic [REG_W-1:0]        guard_ff;
   logic [REG_W-1:0]        max_ff;
   logic                    rsp_valid_ff;
   logic signed [SMP_W-1:0] rsp_data_ff;
   logic                    out_free;
   logic                    in_ready;
   logic                    accept;
   logic [CH_W-1:0]         sel_ch;
   logic [PTR_W-1:0]        wp;
   logic [PTR_W-1:0]        ii;
   logic [PTR_W-1:0]        rd_idx;
   logic [FRAC_BITS-1:0]    frac;
   logic signed [SMP_W-1:0] rd_data;
   logic signed [SMP_W-1:0] y;
   cmdl_ctl_type            ctl;

   // Take a new beat when idle, or while finishing if the output register frees up
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign in_ready = (state_ff == ST_IDLE) || ((state_ff == ST_SUM) && out_free);
   assign accept   = req_bus.valid && in_ready;

   // Strobes for the datapath units
   always_comb begin
      ctl.load_mod  = accept;
      ctl.load_dly  = (state_ff == ST_DLY);
      ctl.load_pos  = (state_ff == ST_POS);
      ctl.rd_en     = (state_ff == ST_RD);
      ctl.step      = step_ff;
      ctl.load_prod = (state_ff == ST_MUL);
   end

   // Pointer lookup follows the incoming channel on accept, the held one otherwise
   assign sel_ch = accept ? req_bus.channel : ch_ff;
   assign rd_idx = ii + PTR_W'(step_ff) - PTR_W'(1);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DLY;
            end
         end
         ST_DLY: begin
            state_in = ST_POS;
         end
         ST_POS: begin
            state_in = ST_RD;
            step_in  = '0;
         end
         ST_RD: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (out_free) begin
               state_in = accept ? ST_DLY : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration registers and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         centre_ff    <= CENTRE_RST;
         depth_ff     <= DEPTH_RST;
         guard_ff     <= GUARD_RST;
         max_ff       <= MAX_RST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if ((state_ff == ST_SUM) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CENTRE: centre_ff <= csr_wr_data;
               CSR_DEPTH:  depth_ff  <= csr_wr_data;
               CSR_GUARD:  guard_ff  <= csr_wr_data;
               CSR_MAX:    max_ff    <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload: hold channel of the item in work, load result beat
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff <= req_bus.channel;
      end
      if ((state_ff == ST_SUM) && out_free) begin
         rsp_data_ff <= y;
      end
   end

   cmdl_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (req_bus.sample_in),
      .sel_ch  (sel_ch),
      .rd_en   (ctl.rd_en),
      .rd_idx  (rd_idx),
      .wp      (wp),
      .rd_data (rd_data)
   );

   cmdl_delay_calc u_delay_calc (
      .clock     (clock),
      .ctl       (ctl),
      .lfo_value (req_bus.lfo_value),
      .centre    (centre_ff),
      .depth     (depth_ff),
      .guard     (guard_ff),
      .max_dly   (max_ff),
      .wp        (wp),
      .ii        (ii),
      .frac      (frac)
   );

   cmdl_interp u_interp (
      .clock   (clock),
      .ctl     (ctl),
      .frac    (frac),
      .rd_data (rd_data),
      .y       (y)
   );

   assign req_bus.ready      = in_ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_data_ff;

endmodule

### design/cmdl_store.sv
// Delay sample memory with per-channel write pointers and fill tracking.
module cmdl_store (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic signed [cmdl_pkg::SMP_W-1:0] wr_data,
   input  logic [cmdl_pkg::CH_W-1:0]        sel_ch,
   input  logic                             rd_en,
   input  logic [cmdl_pkg::PTR_W-1:0]       rd_idx,
   output logic [cmdl_pkg::PTR_W-1:0]       wp,
   output logic signed [cmdl_pkg::SMP_W-1:0] rd_data
);
   import cmdl_pkg::*;

   logic signed [SMP_W-1:0] mem [MEM_DEPTH];
   logic [PTR_W-1:0]        wp_ff [CHANNELS];
   logic [CHANNELS-1:0]     full_ff;
   logic signed [SMP_W-1:0] rdata_ff;
   logic                    hit_ff;
   logic                    hit_in;
   logic                    wrap;
   logic [PTR_W-1:0]        wp_next;

   // Pointer of the selected channel and its successor
   assign wp      = wp_ff[sel_ch];
   assign wrap    = (wp == PTR_W'(BUFFER_DEPTH - 1));
   assign wp_next = wrap ? '0 : wp + 1'b1;

   // An entry holds data once written: everything below the pointer, or all after a wrap
   assign hit_in = full_ff[sel_ch] || (rd_idx < wp);

   // Advance pointer and fill mark on each write
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '{default: '0};
         full_ff <= '0;
         hit_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            wp_ff[sel_ch] <= wp_next;
            if (wrap) begin
               full_ff[sel_ch] <= 1'b1;
            end
         end
         if (rd_en) begin
            hit_ff <= hit_in;
         end
      end
   end

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{sel_ch, wp}] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[{sel_ch, rd_idx}];
      end
   end

   // Never-written entries read as zero
   assign rd_data = hit_ff ? rdata_ff : '0;

endmodule

### design/cmdl_delay_calc.sv
// Modulated delay, clamp and read position split into integer and fraction.
module cmdl_delay_calc (
   input  logic                              clock,
   input  cmdl_pkg::cmdl_ctl_type            ctl,
   input  logic signed [cmdl_pkg::SMP_W-1:0] lfo_value,
   input  logic [cmdl_pkg::REG_W-1:0]        centre,
   input  logic [cmdl_pkg::REG_W-1:0]        depth,
   input  logic [cmdl_pkg::REG_W-1:0]        guard,
   input  logic [cmdl_pkg::REG_W-1:0]        max_dly,
   input  logic [cmdl_pkg::PTR_W-1:0]        wp,
   output logic [cmdl_pkg::PTR_W-1:0]        ii,
   output logic [cmdl_pkg::FRAC_BITS-1:0]    frac
);
   import cmdl_pkg::*;

   localparam logic signed [PROD_W-1:0] MOD_HALF = PROD_W'(1) << (LFO_FRAC - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] rnd;
   logic signed [MOD_W-1:0]  modv;
   logic signed [DSUM_W-1:0] dsum;
   logic signed [DSUM_W-1:0] guard_s;
   logic signed [DSUM_W-1:0] max_s;
   logic [REG_W-1:0]         dly_ff;
   logic [REG_W-1:0]         dly_in;
   logic [POS_W-1:0]         pos;
   logic [PTR_W-1:0]         ii_ff;
   logic [FRAC_BITS-1:0]     frac_ff;

   // Swing = depth * lfo
   assign prod_in = $signed({1'b0, depth}) * lfo_value;

   // Round swing half up to delay resolution, add centre, clamp
   always_comb begin
      rnd     = prod_ff + MOD_HALF;
      modv    = MOD_W'(rnd >>> LFO_FRAC);
      dsum    = DSUM_W'($signed({1'b0, centre})) + DSUM_W'(modv);
      guard_s = $signed(DSUM_W'(guard));
      max_s   = $signed(DSUM_W'(max_dly));
      if (dsum < guard_s) begin
         dly_in = guard;
      end else if (dsum > max_s) begin
         dly_in = max_dly;
      end else begin
         dly_in = dsum[REG_W-1:0];
      end
   end

   // Read position behind the advanced pointer, wrapping over the buffer
   assign pos = {wp, {FRAC_BITS{1'b0}}} - POS_W'(dly_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_mod) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_dly) begin
         dly_ff <= dly_in;
      end
      if (ctl.load_pos) begin
         ii_ff   <= pos[POS_W-1:FRAC_BITS];
         frac_ff <= pos[FRAC_BITS-1:0];
      end
   end

   assign ii   = ii_ff;
   assign frac = frac_ff;

endmodule

### design/cmdl_interp.sv
// Catmull-Rom weights, tap products and rounded, saturated sum.
module cmdl_interp (
   input  logic                              clock,
   input  cmdl_pkg::cmdl_ctl_type            ctl,
   input  logic [cmdl_pkg::FRAC_BITS-1:0]    frac,
   input  logic signed [cmdl_pkg::SMP_W-1:0] rd_data,
   output logic signed [cmdl_pkg::SMP_W-1:0] y
);
   import cmdl_pkg::*;

   localparam logic signed [IW-1:0]    W_PEAK   = IW'(1) << WSCALE;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (WSCALE - 1);
   localparam logic signed [Y_W-1:0]   SAT_HI   = Y_W'((1 << (SMP_W - 1)) - 1);
   localparam logic signed [Y_W-1:0]   SAT_LO   = -SAT_HI - Y_W'(1);

   logic [2*FRAC_BITS-1:0]  u2_ff;
   logic [3*FRAC_BITS-1:0]  u3_ff;
   logic signed [IW-1:0]    a1;
   logic signed [IW-1:0]    a2;
   logic signed [IW-1:0]    a3;
   logic signed [W_W-1:0]   w_in  [TAPS];
   logic signed [W_W-1:0]   w_ff  [TAPS];
   logic signed [SMP_W-1:0] tap_ff [TAPS-1];
   logic signed [SMP_W-1:0] tap   [TAPS];
   logic signed [P_W-1:0]   prod_ff [TAPS];
   logic signed [ACC_W-1:0] acc;
   logic signed [Y_W-1:0]   yr;
   logic                    u2_en;
   logic                    u3_en;
   logic                    w_en;
   logic                    cap_en;

   // Powers of the fraction come from the pointer sweep, one per read step
   assign u2_en  = ctl.rd_en && (ctl.step == STEP_W'(0));
   assign u3_en  = ctl.rd_en && (ctl.step == STEP_W'(1));
   assign w_en   = ctl.rd_en && (ctl.step == STEP_W'(2));
   assign cap_en = ctl.rd_en && (ctl.step != STEP_W'(0));

   // Exact weights at scale 2^WSCALE (s = 2^FRAC_BITS)
   always_comb begin
      a1 = $signed(IW'(frac));
      a2 = $signed(IW'(u2_ff));
      a3 = $signed(IW'(u3_ff));
      w_in[0] = W_W'(-a3 + (a2 <<< (FRAC_BITS + 1)) - (a1 <<< (2 * FRAC_BITS)));
      w_in[1] = W_W'((a3 <<< 1) + a3 - (a2 <<< (FRAC_BITS + 2)) - (a2 <<< FRAC_BITS)
                     + W_PEAK);
      w_in[2] = W_W'(-(a3 <<< 1) - a3 + (a2 <<< (FRAC_BITS + 2))
                     + (a1 <<< (2 * FRAC_BITS)));
      w_in[3] = W_W'(a3 - (a2 <<< FRAC_BITS));
   end

   // Last tap is taken straight from the memory output
   always_comb begin
      for (int k = 0; k < TAPS - 1; k++) begin
         tap[k] = tap_ff[k];
      end
      tap[TAPS-1] = rd_data;
   end

   always_ff @(posedge clock) begin
      if (u2_en) begin
         u2_ff <= frac * frac;
      end
      if (u3_en) begin
         u3_ff <= u2_ff * frac;
      end
      if (w_en) begin
         w_ff <= w_in;
      end
      // shift taps in as they come back from memory
      if (cap_en) begin
         for (int k = 0; k < TAPS - 2; k++) begin
            tap_ff[k] <= tap_ff[k+1];
         end
         tap_ff[TAPS-2] <= rd_data;
      end
      if (ctl.load_prod) begin
         for (int k = 0; k < TAPS; k++) begin
            prod_ff[k] <= w_ff[k] * tap[k];
         end
      end
   end

   // Sum, round half up to Q1.15, saturate
   always_comb begin
      acc = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2])
            + ACC_W'(prod_ff[3]);
      yr  = Y_W'((acc + RND_HALF) >>> WSCALE);
      if (yr > SAT_HI) begin
         y = SAT_HI[SMP_W-1:0];
      end else if (yr < SAT_LO) begin
         y = SAT_LO[SMP_W-1:0];
      end else begin
         y = yr[SMP_W-1:0];
      end
   end

endmodule

### design/cmdl_checker.sv
// Port-level checks on the delay line handshakes, bound to the top level.
module cmdl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [cmdl_pkg::SMP_W-1:0] sample_out
);
   import cmdl_pkg::*;

   logic [1:0] pend_ff;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Count items accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_beat && !rsp_beat) begin
         pend_ff <= pend_ff + 1'b1;
      end else if (rsp_beat && !req_beat) begin
         pend_ff <= pend_ff - 1'b1;
      end
   end

   // Output channel is empty right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat offered right after reset");

   // One item in work at a time: busy in the cycle after a beat is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("input ready in the cycle after an accepted beat");

   // No result beat without an item behind it
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pend_ff != 2'd0))
      else $error("result beat offered with no item outstanding");

   // At most one item in work and one waiting at the output
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two items outstanding");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out))
      else $error("stalled result beat dropped or changed");

endmodule

bind cubic_modulated_delay_line cmdl_checker u_cmdl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .sample_out (rsp_bus.sample_out)
);

### tb/cmdl_checker.sv
// Output checker for the modulated delay line: predicts every output sample and compares.
module cmdl_sample_checker (
   input  logic                           clock,
   input  logic                           reset,
   cmdl_req_if                            req_bus,
   cmdl_rsp_if                            rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [cmdl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cmdl_pkg::REG_W-1:0]     csr_wr_data,
   output int                             mismatches,
   output int                             outstanding,
   output int                             compared
);
   timeunit 1ns;
   timeprecision 1ps;
   import cmdl_pkg::*;

   localparam longint SAT_HI = 2 ** (SMP_W - 1) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;
   localparam int     Q30    = 30;

   // Shadow registers and shadow delay store
   logic [REG_W-1:0]        centre_q, depth_q, guard_q, max_q;
   logic signed [SMP_W-1:0] history [CHANNELS][BUFFER_DEPTH];
   logic [PTR_W-1:0]        head [CHANNELS];

   // Predicted output samples, oldest first
   logic signed [SMP_W-1:0] expected_q [$];
   int                      n_bad, n_cmp;

   // Shift right by sh, rounding half up (floor of value plus one half)
   function automatic longint round_half_up(longint v, int sh);
      if (sh <= 0)
         return v;
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   // Bring an exact weight at scale 2^WSCALE to Q2.30
   function automatic longint weight_q30(longint w);
      if (WSCALE >= Q30)
         return round_half_up(w, WSCALE - Q30);
      return w <<< (Q30 - WSCALE);
   endfunction

   // Store one sample, advance the channel pointer, and interpolate the delayed output
   function automatic logic signed [SMP_W-1:0] delayed_sample(
      input logic [CH_W-1:0]        ch,
      input logic signed [SMP_W-1:0] smp,
      input logic signed [SMP_W-1:0] lfo
   );
      longint           dly, span, pos, base, u, s, u2, u3, s2, s3, acc, y;
      longint           w [TAPS];
      logic [PTR_W-1:0] wp, tap;
      int               k;

      // modulate and clamp: guard wins when the delay is below it
      dly = longint'(centre_q) + round_half_up(longint'(depth_q) * longint'(lfo), LFO_FRAC);
      if (dly < longint'(guard_q))
         dly = longint'(guard_q);
      else if (dly > longint'(max_q))
         dly = longint'(max_q);

      // write, then advance the pointer around the buffer
      history[ch][head[ch]] = smp;
      wp       = head[ch] + 1'b1;
      head[ch] = wp;

      // read position behind the advanced pointer, wrapped to the buffer
      span = longint'(BUFFER_DEPTH) << FRAC_BITS;
      pos  = ((longint'(wp) << FRAC_BITS) + span - (dly % span)) % span;
      base = pos >> FRAC_BITS;
      u    = pos & ((longint'(1) << FRAC_BITS) - 1);
      s    = longint'(1) << FRAC_BITS;
      u2   = u * u;
      u3   = u2 * u;
      s2   = s * s;
      s3   = s2 * s;

      // Catmull-Rom weights for taps i-1 .. i+2
      w[0] = weight_q30(-u3 + 2 * u2 * s - u * s2);
      w[1] = weight_q30(3 * u3 - 5 * u2 * s + 2 * s3);
      w[2] = weight_q30(-3 * u3 + 4 * u2 * s + u * s2);
      w[3] = weight_q30(u3 - u2 * s);

      acc = 0;
      for (k = 0; k < TAPS; k++) begin
         tap = PTR_W'(base + BUFFER_DEPTH - 1 + k);
         acc += w[k] * longint'(history[ch][tap]);
      end

      // round to Q1.15 and saturate
      y = round_half_up(acc, Q30);
      if (y > SAT_HI)
         y = SAT_HI;
      else if (y < SAT_LO)
         y = SAT_LO;
      return SMP_W'(y);
   endfunction

   // Track register writes, predict on each input beat, compare on each output beat
   always @(posedge clock) begin
      logic signed [SMP_W-1:0] want;
      if (reset) begin
         centre_q = CENTRE_RST;
         depth_q  = DEPTH_RST;
         guard_q  = GUARD_RST;
         max_q    = MAX_RST;
         for (int c = 0; c < CHANNELS; c++) begin
            head[c] = '0;
            for (int a = 0; a < BUFFER_DEPTH; a++)
               history[c][a] = '0;
         end
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CENTRE: centre_q = csr_wr_data;
               CSR_DEPTH:  depth_q  = csr_wr_data;
               CSR_GUARD:  guard_q  = csr_wr_data;
               CSR_MAX:    max_q    = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               n_bad++;
               $display("%0t: sample_out beat with nothing expected: expected none, actual %0d",
                        $time, rsp_bus.sample_out);
            end else begin
               want = expected_q.pop_front();
               n_cmp++;
               if (rsp_bus.sample_out !== want) begin
                  n_bad++;
                  $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                           $time, want, rsp_bus.sample_out);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_q.push_back(delayed_sample(req_bus.channel, req_bus.sample_in,
                                                req_bus.lfo_value));
      end
      mismatches  <= n_bad;
      outstanding <= expected_q.size();
      compared    <= n_cmp;
   end

endmodule

### tb/testbench.sv
// Test top for the modulated delay line: stimulus, receiver stalls, watchdog and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cmdl_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 240;
   localparam int HOLD_AFTER   = 60;
   localparam int RANDOM_ITEMS = 550;
   localparam int CALM_ITEMS   = 60;
   localparam int TAIL_CYCLES  = 32;
   localparam int UNIT         = 2 ** FRAC_BITS;

   localparam logic [REG_W-1:0]        REG_ALL  = '1;
   localparam logic [REG_W-1:0]        MAX_TOP  = 21'd2096128;
   localparam logic signed [SMP_W-1:0] FULL_POS = 16'sh7FFF;
   localparam logic signed [SMP_W-1:0] FULL_NEG = 16'sh8000;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [REG_W-1:0]     csr_wr_data;

   int mismatches, outstanding, compared;
   int beats_sent, results_seen, settings, holds;
   bit calm;
   int gap_pct, stall_pct;

   cmdl_req_if req_ch ();
   cmdl_rsp_if rsp_ch ();

   cubic_modulated_delay_line uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   cmdl_sample_checker sample_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .compared    (compared)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stall bursts, one long hold-off to back the block up
   initial begin : receiver
      int stall_left;
      bit held;
      stall_left    = 0;
      held          = 1'b0;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            if (rsp_ch.valid && rsp_ch.ready)
               results_seen++;
            if (stall_left > 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else if (!held && results_seen >= HOLD_AFTER) begin
               held       = 1'b1;
               holds++;
               stall_left = HOLD_CYCLES - 1;
               rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(99) < stall_pct) begin
               stall_left = $urandom_range(0, 7);
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** cubic_modulated_delay_line: FAILED **");
            $finish;
         end
      end
   end

   // Offer one beat and hold it until accepted; then maybe idle a burst
   task automatic send_beat(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] smp,
                            input logic signed [SMP_W-1:0] lfo);
      req_ch.valid     <= 1'b1;
      req_ch.channel   <= ch;
      req_ch.sample_in <= smp;
      req_ch.lfo_value <= lfo;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      beats_sent++;
      if (!calm && $urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every predicted sample has come back
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // Reprogram all four delay registers with the block idle
   task automatic program_regs(input logic [REG_W-1:0] centre, depth, guard, top);
      drain();
      write_reg(CSR_CENTRE, centre);
      write_reg(CSR_DEPTH, depth);
      write_reg(CSR_GUARD, guard);
      write_reg(CSR_MAX, top);
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   // Stimulus: directed corners, random phases, then a calm tail
   initial begin : stimulus
      int                      k, n, r, random_sent;
      logic [CH_W-1:0]         ch;
      logic signed [SMP_W-1:0] smp, lfo;
      logic [REG_W-1:0]        c, d, g, m;

      reset            = 1'b1;
      calm             = 1'b0;
      gap_pct          = 0;
      stall_pct        = 0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_CENTRE;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.channel   = '0;
      req_ch.sample_in = '0;
      req_ch.lfo_value = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      send_beat(1'b0, FULL_POS, FULL_NEG);
      send_beat(1'b1, FULL_NEG, FULL_POS);

      // zero delay: only the newest neighbors and stale slots are read
      program_regs('0, '0, '0, MAX_TOP);
      send_beat(1'b0, FULL_POS, 16'sh0000);
      send_beat(1'b0, FULL_NEG, FULL_NEG);
      send_beat(1'b1, 16'sh1234, FULL_POS);
      send_beat(1'b0, 16'sh0000, 16'sh0000);

      // 2.5 samples +/- 1: full-scale alternation overshoots and saturates
      program_regs(21'(2 * UNIT + UNIT / 2), 21'(UNIT), '0, MAX_TOP);
      for (k = 0; k < 8; k++)
         send_beat(1'b0, k[0] ? FULL_NEG : FULL_POS, SMP_W'(k * 16'h2000));

      // guard above max: below guard gives guard, else max
      program_regs(21'(UNIT), 21'(3 * UNIT), 21'(3 * UNIT), 21'(UNIT));
      send_beat(1'b1, 16'sh4000, FULL_NEG);
      send_beat(1'b1, 16'shC000, FULL_POS);
      send_beat(1'b1, 16'sh7000, 16'sh0000);

      // all-ones centre and depth: swing from zero delay to the upper clamp
      program_regs(REG_ALL, REG_ALL, '0, MAX_TOP);
      send_beat(1'b0, 16'sh5555, FULL_NEG);
      send_beat(1'b0, 16'shAAAA, FULL_POS);
      send_beat(1'b1, 16'sh0001, 16'sh0000);

      // all-ones guard: nearly a whole buffer back, read position wraps
      program_regs('0, '0, REG_ALL, '0);
      send_beat(1'b0, FULL_POS, 16'sh0001);
      send_beat(1'b1, FULL_NEG, 16'shFFFF);

      // random phases, each under its own register setting and idling mix
      random_sent = 0;
      ch          = 1'b0;
      smp         = '0;
      while (random_sent < RANDOM_ITEMS - CALM_ITEMS) begin
         r = $urandom_range(9);
         if (r <= 5) begin
            c = REG_W'($urandom_range(0, 24 * UNIT));
            d = REG_W'($urandom_range(0, 8 * UNIT));
            g = REG_W'($urandom_range(0, 2 * UNIT));
            m = REG_W'($urandom_range(16 * UNIT, 64 * UNIT));
         end else if (r <= 7) begin
            m = REG_W'($urandom_range(0, 4 * UNIT));
            g = REG_W'($urandom_range(m + 1, 8 * UNIT));
            c = REG_W'($urandom_range(0, 12 * UNIT));
            d = REG_W'($urandom_range(0, 8 * UNIT));
         end else if (r == 8) begin
            c = REG_W'($urandom);
            d = REG_W'($urandom);
            g = REG_W'($urandom);
            m = REG_W'($urandom_range(0, MAX_TOP));
         end else begin
            c = $urandom_range(1) ? REG_ALL : '0;
            d = REG_ALL;
            g = $urandom_range(1) ? REG_ALL : '0;
            m = $urandom_range(1) ? MAX_TOP : '0;
         end
         case ($urandom_range(2))
            0: gap_pct <= 0;
            1: gap_pct <= 15;
            default: gap_pct <= 40;
         endcase
         case ($urandom_range(2))
            0: stall_pct <= 0;
            1: stall_pct <= 10;
            default: stall_pct <= 35;
         endcase
         program_regs(c, d, g, m);

         n = $urandom_range(30, 70);
         if (n > RANDOM_ITEMS - CALM_ITEMS - random_sent)
            n = RANDOM_ITEMS - CALM_ITEMS - random_sent;
         for (k = 0; k < n; k++) begin
            if ($urandom_range(3) == 0)
               ch = ~ch;
            case ($urandom_range(9))
               0:       smp = $urandom_range(1) ? FULL_POS : FULL_NEG;
               1, 2, 3: smp = smp + SMP_W'($urandom_range(0, 2047)) - SMP_W'(1024);
               default: smp = SMP_W'($urandom);
            endcase
            case ($urandom_range(9))
               0:       lfo = $urandom_range(1) ? FULL_POS : FULL_NEG;
               1:       lfo = '0;
               default: lfo = SMP_W'($urandom);
            endcase
            send_beat(ch, smp, lfo);
            random_sent++;
         end
      end

      // calm tail: short delays, no idling on either side
      calm <= 1'b1;
      program_regs(21'(4 * UNIT + 77), 21'(3 * UNIT), 21'(UNIT / 2), 21'(12 * UNIT));
      for (k = 0; k < CALM_ITEMS; k++) begin
         ch  = CH_W'($urandom_range(1));
         smp = SMP_W'($urandom);
         lfo = SMP_W'($urandom);
         send_beat(ch, smp, lfo);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d beats on both channels under %0d register settings,", beats_sent,
               settings);
      $display("compared %0d output samples, %0d long receiver hold-off(s).", compared, holds);
      if (mismatches == 0 && outstanding == 0)
         $display("** cubic_modulated_delay_line: PASSED **");
      else
         $display("** cubic_modulated_delay_line: FAILED **");
      $finish;
   end

endmodule
